// ===== rtl/sexp_tok_pkg.sv =====
// ----------------------------------------------------------------------------
// sexp_tok_pkg
// Shared types, character codes, event codes and helpers for the
// s-expression tokenizer.
// ----------------------------------------------------------------------------
package sexp_tok_pkg;

  localparam int NumBits = 32;
  localparam logic [NumBits-1:0] Limit = {1'b1, {(NumBits-1){1'b0}}};

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeComment = 3'd1;
  localparam logic [2:0] ModeString  = 3'd2;
  localparam logic [2:0] ModeEscape  = 3'd3;
  localparam logic [2:0] ModeAtom    = 3'd4;

  localparam logic [3:0] EvText   = 4'd0;
  localparam logic [3:0] EvOpen   = 4'd1;
  localparam logic [3:0] EvClose  = 4'd2;
  localparam logic [3:0] EvQuote  = 4'd3;
  localparam logic [3:0] EvNumber = 4'd4;
  localparam logic [3:0] EvString = 4'd5;
  localparam logic [3:0] EvSymbol = 4'd6;
  localparam logic [3:0] EvError  = 4'd7;
  localparam logic [3:0] EvEnd    = 4'd8;

  localparam logic [1:0] ErrQuoteInAtom  = 2'd0;
  localparam logic [1:0] ErrNonDigit     = 2'd1;
  localparam logic [1:0] ErrUntermString = 2'd2;
  localparam logic [1:0] ErrBadNumber    = 2'd3;

  localparam logic [7:0] ChOpen    = 8'h28;
  localparam logic [7:0] ChClose   = 8'h29;
  localparam logic [7:0] ChQuote   = 8'h27;
  localparam logic [7:0] ChSemi    = 8'h3b;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChN       = 8'h6e;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChBslash  = 8'h5c;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [3:0]         event_res;
    logic [7:0]         text_byte;
    logic signed [31:0] number_value;
    logic [1:0]         error_code;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               negative_start;
    logic               still_numeric;
    logic               seen_digit;
    logic [NumBits-1:0] accumulated_value;
    logic               overflowed;
  } lex_state_t;

  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } step_res_t;

  function automatic out_t mk_res(logic [3:0] ev, logic [7:0] tb,
                                  logic signed [31:0] num, logic [1:0] err);
    out_t r;
    r.event_res    = ev;
    r.text_byte    = tb;
    r.number_value = num;
    r.error_code   = err;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/s_expression_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// s_expression_tokenizer_core
// Streaming s-expression lexer: one source byte a word in, token events out.
// ----------------------------------------------------------------------------
// One source word is taken per clock cycle while the queue has room, and
// its token events (none, one or two) land in a four-entry result queue on
// the same edge, so the first event is held in the queue from the cycle
// after the byte is accepted. The output side drains one event per cycle
// while tok_ready is high; bytes that finish an atom with a bracket, and
// end-of-source words that close a pending atom or string, give two
// events. Input is held off only while the queue lacks room for two events.
// ----------------------------------------------------------------------------
module s_expression_tokenizer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  sexp_tok_pkg::in_t  src,
  output logic               tok_valid,
  input  logic               tok_ready,
  output sexp_tok_pkg::out_t tok
);
  import sexp_tok_pkg::*;

  lex_state_t lex;
  lex_state_t lex_next;
  step_res_t  step_res;
  logic       accept;

  assign accept = src_valid && src_ready;

  sexp_tok_step u_step (
    .src      (src),
    .lex      (lex),
    .lex_next (lex_next),
    .res      (step_res)
  );

  sexp_tok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_res  (step_res),
    .room      (src_ready),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lex.mode              <= ModeIdle;
      lex.negative_start    <= 1'b0;
      lex.still_numeric     <= 1'b0;
      lex.seen_digit        <= 1'b0;
      lex.accumulated_value <= '0;
      lex.overflowed        <= 1'b0;
    end else if (accept) begin
      lex <= lex_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept && src.end_of_input |=> lex.mode == ModeIdle && !lex.still_numeric)
    else $error("end of source did not return the lexer to idle");

  assert property (@(posedge clk) disable iff (rst)
    lex.accumulated_value <= Limit)
    else $error("number magnitude beyond signed limit");

  assert property (@(posedge clk) disable iff (rst)
    lex.overflowed |-> lex.seen_digit && lex.mode == ModeAtom)
    else $error("overflow flagged without a digit");

  assert property (@(posedge clk) disable iff (rst)
    lex.mode != ModeAtom |-> !lex.seen_digit && !lex.negative_start &&
                             lex.accumulated_value == '0)
    else $error("atom state left over outside an atom");

endmodule

// ===== rtl/sexp_tok_step.sv =====
// ----------------------------------------------------------------------------
// sexp_tok_step
// Per-byte lexer step: next scan state and up to two token events.
// ----------------------------------------------------------------------------
module sexp_tok_step (
  input  sexp_tok_pkg::in_t        src,
  input  sexp_tok_pkg::lex_state_t lex,
  output sexp_tok_pkg::lex_state_t lex_next,
  output sexp_tok_pkg::step_res_t  res
);
  import sexp_tok_pkg::*;

  logic [7:0]                b;
  logic                      is_digit;
  logic                      is_sep;
  logic [3:0]                dval;
  logic [NumBits+3:0]        acc_ext;
  logic [NumBits+3:0]        acc_sum;
  logic                      sum_ovf;
  logic [NumBits-1:0]        mag;
  logic signed [NumBits-1:0] sval;
  logic                      finish_err;
  out_t                      finish_res;
  lex_state_t                cleared;
  logic [1:0]                n;
  out_t                      r0;
  out_t                      r1;

  assign b        = src.in_byte;
  assign is_digit = (b >= ChZero) && (b <= ChNine);
  assign is_sep   = (b == ChSpace) || (b == ChNewline);
  assign dval     = 4'(b - ChZero);

  assign acc_ext = {4'b0, lex.accumulated_value};
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + {{NumBits{1'b0}}, dval};
  assign sum_ovf = acc_sum > {4'b0, Limit};

  assign mag  = lex.negative_start ? -lex.accumulated_value : lex.accumulated_value;
  assign sval = signed'(mag);

  assign finish_err = !lex.seen_digit || lex.overflowed ||
                      (!lex.negative_start && (lex.accumulated_value >= Limit));

  always_comb begin
    if (!lex.still_numeric) begin
      finish_res = mk_res(EvSymbol, 8'd0, 32'sd0, ErrQuoteInAtom);
    end else if (finish_err) begin
      finish_res = mk_res(EvError, 8'd0, 32'sd0, ErrBadNumber);
    end else begin
      finish_res = mk_res(EvNumber, 8'd0, 32'(sval), ErrQuoteInAtom);
    end
  end

  always_comb begin
    cleared                   = lex;
    cleared.mode              = ModeIdle;
    cleared.negative_start    = 1'b0;
    cleared.still_numeric     = 1'b0;
    cleared.seen_digit        = 1'b0;
    cleared.accumulated_value = '0;
    cleared.overflowed        = 1'b0;
  end

  always_comb begin
    lex_next = lex;
    n        = 2'd0;
    r0       = mk_res(EvText, 8'd0, 32'sd0, ErrQuoteInAtom);
    r1       = r0;
    if (src.end_of_input) begin
      lex_next = cleared;
      if (lex.mode == ModeAtom) begin
        r0 = finish_res;
        r1 = mk_res(EvEnd, 8'd0, 32'sd0, ErrQuoteInAtom);
        n  = 2'd2;
      end else if ((lex.mode == ModeString) || (lex.mode == ModeEscape)) begin
        r0 = mk_res(EvError, 8'd0, 32'sd0, ErrUntermString);
        r1 = mk_res(EvEnd, 8'd0, 32'sd0, ErrQuoteInAtom);
        n  = 2'd2;
      end else begin
        r0 = mk_res(EvEnd, 8'd0, 32'sd0, ErrQuoteInAtom);
        n  = 2'd1;
      end
    end else begin
      unique case (lex.mode)
        ModeComment: begin
          if (b == ChNewline) lex_next.mode = ModeIdle;
        end
        ModeString: begin
          if (b == ChDquote) begin
            r0 = mk_res(EvString, 8'd0, 32'sd0, ErrQuoteInAtom);
            n  = 2'd1;
            lex_next.mode = ModeIdle;
          end else if (b == ChBslash) begin
            lex_next.mode = ModeEscape;
          end else if (b == ChNewline) begin
            r0 = mk_res(EvError, 8'd0, 32'sd0, ErrUntermString);
            n  = 2'd1;
            lex_next.mode = ModeIdle;
          end else begin
            r0 = mk_res(EvText, b, 32'sd0, ErrQuoteInAtom);
            n  = 2'd1;
          end
        end
        ModeEscape: begin
          n = 2'd1;
          if (b == ChNewline) begin
            r0 = mk_res(EvError, 8'd0, 32'sd0, ErrUntermString);
            lex_next.mode = ModeIdle;
          end else begin
            r0 = mk_res(EvText, (b == ChN) ? ChNewline : b, 32'sd0, ErrQuoteInAtom);
            lex_next.mode = ModeString;
          end
        end
        ModeAtom: begin
          if (is_sep || (b == ChOpen) || (b == ChClose)) begin
            lex_next = cleared;
            r0 = finish_res;
            n  = 2'd1;
            if (b == ChOpen) begin
              r1 = mk_res(EvOpen, 8'd0, 32'sd0, ErrQuoteInAtom);
              n  = 2'd2;
            end else if (b == ChClose) begin
              r1 = mk_res(EvClose, 8'd0, 32'sd0, ErrQuoteInAtom);
              n  = 2'd2;
            end
          end else if (b == ChDquote) begin
            lex_next = cleared;
            r0 = mk_res(EvError, 8'd0, 32'sd0, ErrQuoteInAtom);
            n  = 2'd1;
          end else if (lex.still_numeric && is_digit) begin
            lex_next.seen_digit = 1'b1;
            if (!lex.overflowed) begin
              if (sum_ovf) begin
                lex_next.overflowed = 1'b1;
              end else begin
                lex_next.accumulated_value = acc_sum[NumBits-1:0];
              end
            end
            r0 = mk_res(EvText, b, 32'sd0, ErrQuoteInAtom);
            n  = 2'd1;
          end else if (lex.still_numeric && !lex.negative_start) begin
            lex_next = cleared;
            r0 = mk_res(EvError, 8'd0, 32'sd0, ErrNonDigit);
            n  = 2'd1;
          end else begin
            lex_next.still_numeric = 1'b0;
            r0 = mk_res(EvText, b, 32'sd0, ErrQuoteInAtom);
            n  = 2'd1;
          end
        end
        default: begin
          lex_next.mode = ModeIdle;
          if (is_sep) begin
            n = 2'd0;
          end else if (b == ChOpen) begin
            r0 = mk_res(EvOpen, 8'd0, 32'sd0, ErrQuoteInAtom);
            n  = 2'd1;
          end else if (b == ChClose) begin
            r0 = mk_res(EvClose, 8'd0, 32'sd0, ErrQuoteInAtom);
            n  = 2'd1;
          end else if (b == ChQuote) begin
            r0 = mk_res(EvQuote, 8'd0, 32'sd0, ErrQuoteInAtom);
            n  = 2'd1;
          end else if (b == ChSemi) begin
            lex_next.mode = ModeComment;
          end else if (b == ChDquote) begin
            lex_next.mode = ModeString;
          end else begin
            lex_next      = cleared;
            lex_next.mode = ModeAtom;
            if (b == ChMinus) begin
              lex_next.negative_start = 1'b1;
              lex_next.still_numeric  = 1'b1;
            end else if (is_digit) begin
              lex_next.still_numeric     = 1'b1;
              lex_next.seen_digit        = 1'b1;
              lex_next.accumulated_value = NumBits'(dval);
            end
            r0 = mk_res(EvText, b, 32'sd0, ErrQuoteInAtom);
            n  = 2'd1;
          end
        end
      endcase
    end
    if (n == 2'd1) r0.last_result = 1'b1;
    if (n == 2'd2) r1.last_result = 1'b1;
    res.count  = n;
    res.first  = r0;
    res.second = r1;
  end

endmodule

// ===== rtl/sexp_tok_queue.sv =====
// ----------------------------------------------------------------------------
// sexp_tok_queue
// Small result queue: takes up to two token words a cycle, gives one while tok_ready is high.
// ----------------------------------------------------------------------------
module sexp_tok_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sexp_tok_pkg::step_res_t push_res,
  output logic                    room,
  output logic                    tok_valid,
  input  logic                    tok_ready,
  output sexp_tok_pkg::out_t      tok
);
  import sexp_tok_pkg::*;

  out_t             q [QDepth];
  logic [QPtrW-1:0] head;
  logic [QPtrW-1:0] tail;
  logic [QCntW-1:0] count;
  logic [QCntW-1:0] count_next;
  logic [1:0]       n;
  logic             pop;

  assign n          = push ? push_res.count : 2'd0;
  assign pop        = tok_valid && tok_ready;
  assign count_next = count + QCntW'(n) - QCntW'(pop);
  assign room       = count <= QCntW'(QDepth - 2);
  assign tok_valid  = count != '0;
  assign tok        = q[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + QPtrW'(pop);
      tail  <= tail + QPtrW'(n);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n != 2'd0) q[tail] <= push_res.first;
    if (n == 2'd2) q[tail + QPtrW'(1)] <= push_res.second;
  end

  assert property (@(posedge clk) disable iff (rst) count <= QCntW'(QDepth))
    else $error("result queue count beyond depth");

endmodule
